FILE: design/hdlr_pkg.sv
// Shared types and constants for the Hermite delay-line reader.
// Field widths, default parameter values, item kinds and the
// controller-to-datapath command and status words. No dependencies.
package hdlr_pkg;

    // Default sizes, handed to the top level parameters
    localparam int BUFFER_SIZE_DEF   = 4096;
    localparam int FRACTION_BITS_DEF = 16;
    localparam int SAMPLE_BITS_DEF   = 24;

    // Fixed field widths of the stream words
    localparam int WADDR_W   = 12;
    localparam int WSAMP_W   = 24;
    localparam int RPOS_W    = 28;
    localparam int OUT_W     = 24;
    localparam int S_TDATA_W = 64;
    localparam int M_TDATA_W = 24;

    // Bit offsets of the input fields inside s_tdata
    localparam int WADDR_LSB = 0;
    localparam int WSAMP_LSB = WADDR_LSB + WADDR_W;
    localparam int RPOS_LSB  = WSAMP_LSB + WSAMP_W;

    // Item kinds carried on s_tuser
    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_READ  = 1'b1;

    // Datapath operations, one per controller step
    typedef enum logic [3:0] {
        OP_NONE,
        OP_DIFF,
        OP_SUMS,
        OP_A,
        OP_MULA,
        OP_S1,
        OP_MULS1,
        OP_S2,
        OP_MULS2,
        OP_ROUND,
        OP_OUT
    } dp_op_t;

    typedef struct packed {
        logic       clr_step;    // write zero at the clear counter, advance it
        logic       wr_item;     // store the sample of the word on s_tdata
        logic       load_pos;    // latch index and fraction of a read word
        logic       cap_sample;  // shift the fetched sample into the window
        logic [1:0] fetch_off;   // fetch index is base + fetch_off - 1
        dp_op_t     op;
    } dp_cmd_t;

    typedef struct packed {
        logic clr_last;          // clear counter sits on the last entry
    } dp_stat_t;

endpackage

FILE: design/hdlr_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Standalone; no package needed.
module hdlr_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write, then register the read word
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: design/hdlr_ctrl.sv
// Controller for the Hermite delay-line reader: clear pass, item accept,
// four sample fetches and the Horner step sequence. Uses hdlr_pkg.
module hdlr_ctrl import hdlr_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_tvalid,
    output logic     s_tready,
    input  logic     s_func,
    output logic     m_tvalid,
    input  logic     m_tready,
    output dp_cmd_t  cmd,
    input  dp_stat_t stat
);

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_F0,
        ST_F1,
        ST_F2,
        ST_F3,
        ST_DIFF,
        ST_SUMS,
        ST_A,
        ST_MULA,
        ST_S1,
        ST_MULS1,
        ST_S2,
        ST_MULS2,
        ST_ROUND,
        ST_OUT
    } state_t;

    state_t state_reg, state_next;
    logic   m_tvalid_reg, m_tvalid_next;

    // Next state, commands and output valid
    always_comb begin
        state_next    = state_reg;
        cmd           = '0;
        cmd.op        = OP_NONE;
        s_tready      = 1'b0;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        case (state_reg)
            ST_CLEAR: begin
                cmd.clr_step = 1'b1;
                if (stat.clr_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    if (s_func == FUNC_WRITE) begin
                        cmd.wr_item = 1'b1;
                    end else begin
                        cmd.load_pos = 1'b1;
                        state_next   = ST_F0;
                    end
                end
            end
            ST_F0: begin
                cmd.fetch_off = 2'd0;
                state_next    = ST_F1;
            end
            ST_F1: begin
                cmd.fetch_off  = 2'd1;
                cmd.cap_sample = 1'b1;
                state_next     = ST_F2;
            end
            ST_F2: begin
                cmd.fetch_off  = 2'd2;
                cmd.cap_sample = 1'b1;
                state_next     = ST_F3;
            end
            ST_F3: begin
                cmd.fetch_off  = 2'd3;
                cmd.cap_sample = 1'b1;
                state_next     = ST_DIFF;
            end
            ST_DIFF: begin
                cmd.op     = OP_DIFF;
                state_next = ST_SUMS;
            end
            ST_SUMS: begin
                cmd.op     = OP_SUMS;
                state_next = ST_A;
            end
            ST_A: begin
                cmd.op     = OP_A;
                state_next = ST_MULA;
            end
            ST_MULA: begin
                cmd.op     = OP_MULA;
                state_next = ST_S1;
            end
            ST_S1: begin
                cmd.op     = OP_S1;
                state_next = ST_MULS1;
            end
            ST_MULS1: begin
                cmd.op     = OP_MULS1;
                state_next = ST_S2;
            end
            ST_S2: begin
                cmd.op     = OP_S2;
                state_next = ST_MULS2;
            end
            ST_MULS2: begin
                cmd.op     = OP_MULS2;
                state_next = ST_ROUND;
            end
            ST_ROUND: begin
                cmd.op     = OP_ROUND;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                // Load the output register once it is free or being drained
                if (!m_tvalid_reg || m_tready) begin
                    cmd.op        = OP_OUT;
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state and output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;

endmodule

FILE: design/hdlr_dp.sv
// Datapath for the Hermite delay-line reader: store addressing, sample
// window, coefficient adders, shared multiplier and saturating output.
// Uses hdlr_pkg; drives the ports of one hdlr_ram.
module hdlr_dp import hdlr_pkg::*; #(
    parameter int BUFFER_SIZE   = BUFFER_SIZE_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF,
    parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  dp_cmd_t                        cmd,
    output dp_stat_t                       stat,
    input  logic [S_TDATA_W-1:0]           s_tdata,
    output logic                           ram_we,
    output logic [$clog2(BUFFER_SIZE)-1:0] ram_waddr,
    output logic [SAMPLE_BITS-1:0]         ram_wdata,
    output logic [$clog2(BUFFER_SIZE)-1:0] ram_raddr,
    input  logic [SAMPLE_BITS-1:0]         ram_rdata,
    output logic [M_TDATA_W-1:0]           m_tdata
);

    localparam int IDX_W = $clog2(BUFFER_SIZE);
    localparam int F     = FRACTION_BITS;
    localparam int SW    = SAMPLE_BITS;
    localparam int CW    = SW + 5;          // coefficient and Horner width
    localparam int PW    = CW + F + 1;      // product width

    localparam logic signed [PW-1:0] HALF = {{(PW-F-1){1'b0}}, 1'b1, {F{1'b0}}};
    localparam logic signed [CW:0]   SMAX = {{(CW-SW+2){1'b0}}, {(SW-1){1'b1}}};
    localparam logic signed [CW:0]   SMIN = {{(CW-SW+2){1'b1}}, {(SW-1){1'b0}}};

    // Field extraction
    logic [WADDR_W-1:0]       wr_addr;
    logic [WSAMP_W-1:0]       wr_samp;
    logic [RPOS_W-1:0]        rd_pos;
    logic [IDX_W+WADDR_W-1:0] wr_addr_ext;
    logic [SW+WSAMP_W-1:0]    wr_samp_ext;
    logic [IDX_W+RPOS_W-1:0]  rd_idx_ext;

    assign wr_addr     = s_tdata[WADDR_LSB +: WADDR_W];
    assign wr_samp     = s_tdata[WSAMP_LSB +: WSAMP_W];
    assign rd_pos      = s_tdata[RPOS_LSB +: RPOS_W];
    assign wr_addr_ext = {{IDX_W{1'b0}}, wr_addr};
    assign wr_samp_ext = {{SW{1'b0}}, wr_samp};
    assign rd_idx_ext  = {{IDX_W{1'b0}}, rd_pos} >> F;

    // Clear counter
    logic [IDX_W-1:0] clr_cnt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg <= '0;
        end else if (cmd.clr_step) begin
            clr_cnt_reg <= clr_cnt_reg + IDX_W'(1);
        end
    end

    assign stat.clr_last = (clr_cnt_reg == {IDX_W{1'b1}});

    // Store ports: clear pass or write word on the write side
    logic [IDX_W-1:0] base_reg;
    logic [F-1:0]     frac_reg;

    assign ram_we    = cmd.clr_step || cmd.wr_item;
    assign ram_waddr = cmd.clr_step ? clr_cnt_reg : wr_addr_ext[IDX_W-1:0];
    assign ram_wdata = cmd.clr_step ? '0 : wr_samp_ext[SW-1:0];
    assign ram_raddr = base_reg + IDX_W'(cmd.fetch_off) - IDX_W'(1);

    // Sample window and arithmetic registers
    logic signed [SW-1:0]   xm1_reg, x0_reg, x1_reg;
    logic signed [CW-1:0]   c_reg;
    logic signed [CW-1:0]   w_reg;      // holds V, then W
    logic signed [CW-1:0]   e_reg;      // holds x2 - x0, then V + x2 - x0
    logic signed [CW-1:0]   b_reg;
    logic signed [CW-1:0]   acc_reg;    // A, s1, s2, then rounded s2 term
    logic signed [PW-1:0]   prod_reg;
    logic [M_TDATA_W-1:0]   out_reg;

    logic signed [CW-1:0]   xm1_e, x0_e, x1_e, x2_e;
    logic signed [F:0]      frac_s;
    logic signed [PW-1:0]   mul;
    logic signed [PW-1:0]   prod_sh;
    logic signed [PW-1:0]   prod_rnd;
    logic signed [CW:0]     y_full;
    logic [SW-1:0]          y_sat;
    logic [SW+OUT_W-1:0]    y_ext;

    assign xm1_e  = CW'(xm1_reg);
    assign x0_e   = CW'(x0_reg);
    assign x1_e   = CW'(x1_reg);
    assign x2_e   = CW'(signed'(ram_rdata));
    assign frac_s = signed'({1'b0, frac_reg});

    // Shared multiplier and the shifts that follow it
    assign mul      = acc_reg * frac_s;
    assign prod_sh  = prod_reg >>> F;
    assign prod_rnd = (prod_reg + HALF) >>> (F + 1);

    // Add the center sample and clamp to the sample range
    assign y_full = (CW+1)'(acc_reg) + (CW+1)'(x0_reg);

    always_comb begin
        if (y_full > SMAX) begin
            y_sat = SMAX[SW-1:0];
        end else if (y_full < SMIN) begin
            y_sat = SMIN[SW-1:0];
        end else begin
            y_sat = y_full[SW-1:0];
        end
    end

    assign y_ext = {{OUT_W{1'b0}}, y_sat};

    // Step through the Horner sequence
    always_ff @(posedge aclk) begin
        if (cmd.load_pos) begin
            base_reg <= rd_idx_ext[IDX_W-1:0];
            frac_reg <= rd_pos[F-1:0];
        end
        if (cmd.cap_sample) begin
            xm1_reg <= x0_reg;
            x0_reg  <= x1_reg;
            x1_reg  <= signed'(ram_rdata);
        end
        case (cmd.op)
            OP_DIFF: begin
                c_reg <= x1_e - xm1_e;
                w_reg <= (x0_e - x1_e) <<< 1;
                e_reg <= x2_e - x0_e;
            end
            OP_SUMS: begin
                w_reg <= c_reg + w_reg;
                e_reg <= w_reg + e_reg;
            end
            OP_A: begin
                acc_reg <= w_reg + e_reg;
            end
            OP_MULA: begin
                prod_reg <= mul;
                b_reg    <= w_reg + acc_reg;
            end
            OP_S1: begin
                acc_reg <= signed'(prod_sh[CW-1:0]) - b_reg;
            end
            OP_MULS1: begin
                prod_reg <= mul;
            end
            OP_S2: begin
                acc_reg <= signed'(prod_sh[CW-1:0]) + c_reg;
            end
            OP_MULS2: begin
                prod_reg <= mul;
            end
            OP_ROUND: begin
                acc_reg <= signed'(prod_rnd[CW-1:0]);
            end
            OP_OUT: begin
                out_reg <= y_ext[OUT_W-1:0];
            end
            default: begin
            end
        endcase
    end

    assign m_tdata = out_reg;

endmodule

FILE: design/hermite_delay_line_read.sv
// Top level of the Hermite delay-line reader: controller, datapath and
// sample store. Uses hdlr_pkg, hdlr_ctrl, hdlr_dp and hdlr_ram.
//
//  channel | dir | tdata (low bit up)                          | tuser
//  --------+-----+---------------------------------------------+-----------
//  s_      | in  | write_address 12, write_sample 24, read_pos 28 | func 1
//  m_      | out | interpolated_value 24                       | -
//
// A write word is stored at once and the input stays ready; a read word holds
// the input closed for four fetches through the single read port of the store,
// then ten steps of adders and one shared multiplier for the Horner evaluation.
// After reset a clearing pass writes zeros to every entry, one entry a cycle,
// before s_tready rises.
// A finished result waits in the output register while the next word is
// taken; a read stalls in its last step only while that register is full and not taken.
module hermite_delay_line_read import hdlr_pkg::*; #(
    parameter int BUFFER_SIZE   = BUFFER_SIZE_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF,
    parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // write_address, write_sample, read_position
    input  logic                 s_tuser,   // func
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata    // interpolated_value
);

    localparam int IDX_W = $clog2(BUFFER_SIZE);

    dp_cmd_t                cmd;
    dp_stat_t               stat;
    logic                   ram_we;
    logic [IDX_W-1:0]       ram_waddr;
    logic [SAMPLE_BITS-1:0] ram_wdata;
    logic [IDX_W-1:0]       ram_raddr;
    logic [SAMPLE_BITS-1:0] ram_rdata;

    hdlr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_func   (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    hdlr_dp #(
        .BUFFER_SIZE   (BUFFER_SIZE),
        .FRACTION_BITS (FRACTION_BITS),
        .SAMPLE_BITS   (SAMPLE_BITS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .s_tdata   (s_tdata),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata),
        .m_tdata   (m_tdata)
    );

    hdlr_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (BUFFER_SIZE)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

endmodule

FILE: design/hdlr_checker.sv
// Port-level checks for the Hermite delay-line reader, bound to the top level.
// Uses hdlr_pkg for field widths and item kinds.
module hdlr_checker import hdlr_pkg::*; (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 s_tuser,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    // A stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // The clearing pass keeps the input closed right after reset
    a_clear_busy: assert property (@(posedge aclk)
        !aresetn |=> !s_tready)
        else $error("input ready during clearing pass");

    // A read word occupies the block
    a_read_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser == FUNC_READ) |=> !s_tready)
        else $error("input ready right after a read word");

    // A write word leaves the input ready for the next word
    a_write_quick: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser == FUNC_WRITE) |=> s_tready)
        else $error("input not ready after a write word");

    // A new result comes only out of the busy phase of a read
    a_result_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result appeared while idle");

endmodule

bind hermite_delay_line_read hdlr_checker u_hdlr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
